>>> src/pulse_width_rf_frame_decoder_core_defines.svh
// Assertion macros of the pulse width RF frame decoder, used by pwrfd_decode.
`ifndef PULSE_WIDTH_RF_FRAME_DECODER_CORE_DEFINES_SVH
`define PULSE_WIDTH_RF_FRAME_DECODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PWRFD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PWRFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pwrfd_pkg.sv
// Package with the types and constants of the pulse width RF frame decoder.
package pwrfd_pkg;

  // Frame geometry: pulses that follow the sync pulse.
  localparam int unsigned PULSES_PER_FRAME = 63;
  localparam int unsigned IDX_W = $clog2(PULSES_PER_FRAME + 1);

  localparam int unsigned TIME_W = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_MIN   = 3'd0,
    REG_PULSE_MIN  = 3'd1,
    REG_PULSE_MAX  = 3'd2,
    REG_ONE_THRESH = 3'd3,
    REG_CODE_CONF  = 3'd4,
    REG_CODE_ECO   = 3'd5,
    REG_CODE_FROST = 3'd6,
    REG_CODE_STOP  = 3'd7
  } cfg_idx_e;

  // Matched command codes.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_CONF  = 3'd1,
    CMD_ECO   = 3'd2,
    CMD_FROST = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [TIME_W-1:0] sync_min;
    logic [TIME_W-1:0] pulse_min;
    logic [TIME_W-1:0] pulse_max;
    logic [TIME_W-1:0] one_thresh;
    logic [WORD_W-1:0] code_conf;
    logic [WORD_W-1:0] code_eco;
    logic [WORD_W-1:0] code_frost;
    logic [WORD_W-1:0] code_stop;
  } cfg_t;

  // Held opto and LED drive states.
  typedef struct packed {
    logic green_blink;
    logic red_blink;
    logic green_led;
    logic red_led;
    logic neg_drive;
    logic pos_drive;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{red_led: 1'b1, default: 1'b0};
  localparam flags_t FLAGS_CONF  = '{green_led: 1'b1, default: 1'b0};
  localparam flags_t FLAGS_ECO   =
    '{pos_drive: 1'b1, neg_drive: 1'b1, green_blink: 1'b1, default: 1'b0};
  localparam flags_t FLAGS_FROST = '{neg_drive: 1'b1, red_led: 1'b1, default: 1'b0};
  localparam flags_t FLAGS_STOP  = '{pos_drive: 1'b1, red_blink: 1'b1, default: 1'b0};

  // One result word.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              ok;
    cmd_e              cmd;
    flags_t            flags;
  } result_t;

endpackage

>>> src/pulse_width_rf_frame_decoder_core.sv
// Top level of the pulse width RF frame decoder.
//
// The input channel carries one measured low-pulse width per word on
// low_time_us_i, accepted when in_valid_i is high and in_stall_o is low.
// A sync pulse opens a frame; the following pulses are checked and decoded,
// and one result word leaves on the output channel when a frame completes
// or aborts. Pulses that end nothing produce no output word.
// A result passes the input register, then the result register, on its way to
// out_valid_o. Throughput: one pulse per cycle while no result waits; the
// decode is a single compare, shift and match step between the input register
// and the result register.
// When out_stall_i holds a waiting result, pulses that produce no result still
// flow; a pulse that would produce a result waits and backs up in_stall_o.
// Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i; cfg_ready_o is always high.
// Reset restores the default thresholds and codes, leaves the decoder waiting
// for sync with the red LED flag held, and empties both registers.
module pulse_width_rf_frame_decoder_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pwrfd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pwrfd_pkg::WORD_W-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [pwrfd_pkg::TIME_W-1:0]    low_time_us_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pwrfd_pkg::WORD_W-1:0]    frame_word_o,
  output logic                            frame_ok_o,
  output logic [2:0]                      command_o,
  output logic                            pos_drive_on_o,
  output logic                            neg_drive_on_o,
  output logic                            red_led_on_o,
  output logic                            green_led_on_o,
  output logic                            red_blink_o,
  output logic                            green_blink_o
);
  import pwrfd_pkg::*;

  cfg_t              cfg;
  logic              in_valid_q, in_valid_d;
  logic [TIME_W-1:0] low_time_q;
  logic              in_take;
  logic              step;
  logic              res_valid;
  result_t           res;
  logic              out_free;
  result_t           out_res;

  assign cfg_ready_o = 1'b1;

  pwrfd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  // A registered pulse moves on unless its result finds the output occupied.
  assign step       = in_valid_q && (!res_valid || out_free);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take || (in_valid_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      low_time_q <= low_time_us_i;
    end
  end

  pwrfd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .low_time_i  (low_time_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pwrfd_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_valid),
    .res_i   (res),
    .stall_i (out_stall_i),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .res_o   (out_res)
  );

  // Unpack the result word onto the output ports.
  assign frame_word_o   = out_res.word;
  assign frame_ok_o     = out_res.ok;
  assign command_o      = out_res.cmd;
  assign pos_drive_on_o = out_res.flags.pos_drive;
  assign neg_drive_on_o = out_res.flags.neg_drive;
  assign red_led_on_o   = out_res.flags.red_led;
  assign green_led_on_o = out_res.flags.green_led;
  assign red_blink_o    = out_res.flags.red_blink;
  assign green_blink_o  = out_res.flags.green_blink;

endmodule

>>> src/pwrfd_cfg_regs.sv
// Configuration register file of the pulse width RF frame decoder.
module pwrfd_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [pwrfd_pkg::CFG_IDX_W-1:0] index_i,
  input  logic [pwrfd_pkg::WORD_W-1:0]    data_i,
  output pwrfd_pkg::cfg_t                 cfg_o
);
  import pwrfd_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode the write index; 16-bit registers keep the low half of the data.
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(index_i))
        REG_SYNC_MIN:   cfg_d.sync_min   = data_i[TIME_W-1:0];
        REG_PULSE_MIN:  cfg_d.pulse_min  = data_i[TIME_W-1:0];
        REG_PULSE_MAX:  cfg_d.pulse_max  = data_i[TIME_W-1:0];
        REG_ONE_THRESH: cfg_d.one_thresh = data_i[TIME_W-1:0];
        REG_CODE_CONF:  cfg_d.code_conf  = data_i;
        REG_CODE_ECO:   cfg_d.code_eco   = data_i;
        REG_CODE_FROST: cfg_d.code_frost = data_i;
        REG_CODE_STOP:  cfg_d.code_stop  = data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_min   <= TIME_W'(2500);
      cfg_q.pulse_min  <= TIME_W'(150);
      cfg_q.pulse_max  <= TIME_W'(1600);
      cfg_q.one_thresh <= TIME_W'(500);
      cfg_q.code_conf  <= 32'h2C67_4E90;
      cfg_q.code_eco   <= 32'h2C67_4E91;
      cfg_q.code_frost <= 32'h2C67_4E92;
      cfg_q.code_stop  <= 32'h2C67_4E81;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/pwrfd_decode.sv
// Frame state and combinational pulse decode of the pulse width RF frame decoder.
`include "pulse_width_rf_frame_decoder_core_defines.svh"

module pwrfd_decode (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pwrfd_pkg::cfg_t              cfg_i,
  input  logic                         step_i,
  input  logic [pwrfd_pkg::TIME_W-1:0] low_time_i,
  output logic                         res_valid_o,
  output pwrfd_pkg::result_t           res_o
);
  import pwrfd_pkg::*;

  logic              in_frame_q, in_frame_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [WORD_W-1:0] shift_q, shift_d;
  flags_t            flags_q, flags_d;

  logic              sync_seen;
  logic              out_of_range;
  logic              bit_val;
  logic              even;
  logic              comp_fail;
  logic [IDX_W-1:0]  idx_inc;
  logic [WORD_W-1:0] word_n;
  flags_t            flags_n;
  cmd_e              cmd_n;

  // Pulse classification against the configured limits.
  assign sync_seen    = (low_time_i >= cfg_i.sync_min);
  assign out_of_range = (low_time_i < cfg_i.pulse_min) || (low_time_i > cfg_i.pulse_max);
  assign bit_val      = (low_time_i > cfg_i.one_thresh);
  assign even         = !idx_q[0];
  assign comp_fail    = !even && (bit_val == shift_q[0]);
  assign idx_inc      = idx_q + IDX_W'(1);
  assign word_n       = even ? {shift_q[WORD_W-2:0], bit_val} : shift_q;

  // Command match, first match wins.
  always_comb begin
    cmd_n   = CMD_NONE;
    flags_n = flags_q;
    if (word_n == cfg_i.code_conf) begin
      cmd_n   = CMD_CONF;
      flags_n = FLAGS_CONF;
    end else if (word_n == cfg_i.code_eco) begin
      cmd_n   = CMD_ECO;
      flags_n = FLAGS_ECO;
    end else if (word_n == cfg_i.code_frost) begin
      cmd_n   = CMD_FROST;
      flags_n = FLAGS_FROST;
    end else if (word_n == cfg_i.code_stop) begin
      cmd_n   = CMD_STOP;
      flags_n = FLAGS_STOP;
    end
  end

  // Next frame state and the result word for the current pulse.
  always_comb begin
    in_frame_d  = in_frame_q;
    idx_d       = idx_q;
    shift_d     = shift_q;
    flags_d     = flags_q;
    res_valid_o = 1'b0;
    res_o       = '{word: shift_q, ok: 1'b0, cmd: CMD_NONE, flags: flags_q};
    if (!in_frame_q) begin
      if (sync_seen) begin
        in_frame_d = 1'b1;
        idx_d      = '0;
        shift_d    = '0;
      end
    end else if (out_of_range || comp_fail) begin
      // Aborted frame: report the bits gathered so far.
      res_valid_o = 1'b1;
      in_frame_d  = sync_seen;
      idx_d       = '0;
      shift_d     = '0;
    end else if (idx_inc >= IDX_W'(PULSES_PER_FRAME)) begin
      // Last pulse of a complete frame.
      res_valid_o = 1'b1;
      res_o       = '{word: word_n, ok: 1'b1, cmd: cmd_n, flags: flags_n};
      flags_d     = flags_n;
      in_frame_d  = sync_seen;
      idx_d       = '0;
      shift_d     = '0;
    end else begin
      idx_d   = idx_inc;
      shift_d = word_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      idx_q      <= '0;
      shift_q    <= '0;
      flags_q    <= FLAGS_RESET;
    end else if (step_i) begin
      in_frame_q <= in_frame_d;
      idx_q      <= idx_d;
      shift_q    <= shift_d;
      flags_q    <= flags_d;
    end
  end

  // The pulse index never reaches the frame length.
  `PWRFD_ASSERT_IMPL(a_idx_bound, clk_i, rst_ni, 1'b1,
                     idx_q < IDX_W'(PULSES_PER_FRAME), "pulse index past frame length")
  // Outside a frame the index and shift word are cleared.
  `PWRFD_ASSERT_IMPL(a_idle_clear, clk_i, rst_ni, !in_frame_q,
                     (idx_q == '0) && (shift_q == '0), "stale frame state while idle")
  // A completed or aborted frame leaves the index at zero.
  `PWRFD_ASSERT_NEXT(a_end_clears, clk_i, rst_ni, step_i && res_valid_o,
                     idx_q == '0, "frame end did not clear the pulse index")

endmodule

>>> src/pwrfd_out_reg.sv
// Result register of the pulse width RF frame decoder.
module pwrfd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  pwrfd_pkg::result_t res_i,
  input  logic               stall_i,
  output logic               free_o,
  output logic               valid_o,
  output pwrfd_pkg::result_t res_o
);
  import pwrfd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // The register can take a new word when empty or being drained this cycle.
  assign free_o  = !valid_q || !stall_i;
  assign valid_d = load_i || (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds while stalled.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> sim/pulse_width_rf_frame_decoder_core_tb.sv
// Self-checking testbench for the pulse width RF frame decoder core.
module pulse_width_rf_frame_decoder_core_tb;
  import pwrfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PER_SETTING = 40;
  localparam int SETTINGS_COUNT = 6;
  localparam int NO_ERROR = 63;

  localparam cfg_t RESET_CFG = '{
    sync_min: 16'd2500, pulse_min: 16'd150, pulse_max: 16'd1600, one_thresh: 16'd500,
    code_conf: 32'h2C674E90, code_eco: 32'h2C674E91, code_frost: 32'h2C674E92,
    code_stop: 32'h2C674E81};

  // Rows of the directed table: a single pulse or a whole well-formed frame.
  typedef enum logic {ROW_PULSE, ROW_FRAME} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] value;
    logic        typed;
    result_t     frame;
  } stim_row_t;

  localparam result_t NO_FRAME = '0;
  localparam result_t ABORT_EMPTY = '{32'h0, 1'b0, CMD_NONE, FLAGS_RESET};
  localparam result_t ABORT_ONE = '{32'h1, 1'b0, CMD_NONE, FLAGS_RESET};

  localparam stim_row_t DIRECTED_ROWS [24] = '{
    '{ROW_PULSE, 32'd0,     1'b0, NO_FRAME},
    '{ROW_PULSE, 32'd2499,  1'b0, NO_FRAME},
    '{ROW_PULSE, 32'd65535, 1'b0, NO_FRAME},
    '{ROW_PULSE, 32'd0,     1'b1, ABORT_EMPTY},
    '{ROW_PULSE, 32'd2500,  1'b0, NO_FRAME},
    // An out-of-range pulse that is also long enough to open the next frame.
    '{ROW_PULSE, 32'd65535, 1'b1, ABORT_EMPTY},
    '{ROW_PULSE, 32'd1600,  1'b0, NO_FRAME},
    // The odd pulse repeats the bit instead of its complement.
    '{ROW_PULSE, 32'd1600,  1'b1, ABORT_ONE},
    '{ROW_PULSE, 32'd2500,  1'b0, NO_FRAME},
    '{ROW_PULSE, 32'd150,   1'b0, NO_FRAME},
    '{ROW_PULSE, 32'd1600,  1'b0, NO_FRAME},
    '{ROW_PULSE, 32'd501,   1'b0, NO_FRAME},
    '{ROW_PULSE, 32'd500,   1'b0, NO_FRAME},
    '{ROW_PULSE, 32'd1601,  1'b1, ABORT_ONE},
    '{ROW_PULSE, 32'd149,   1'b0, NO_FRAME},
    '{ROW_PULSE, 32'd65535, 1'b0, NO_FRAME},
    '{ROW_PULSE, 32'd149,   1'b1, ABORT_EMPTY},
    '{ROW_FRAME, 32'h2C674E90, 1'b1, '{32'h2C674E90, 1'b1, CMD_CONF, FLAGS_CONF}},
    '{ROW_FRAME, 32'h2C674E91, 1'b1, '{32'h2C674E91, 1'b1, CMD_ECO, FLAGS_ECO}},
    '{ROW_FRAME, 32'h2C674E92, 1'b1, '{32'h2C674E92, 1'b1, CMD_FROST, FLAGS_FROST}},
    '{ROW_FRAME, 32'h2C674E81, 1'b1, '{32'h2C674E81, 1'b1, CMD_STOP, FLAGS_STOP}},
    // Complete frames that match no code leave the flags as they were.
    '{ROW_FRAME, 32'h00000000, 1'b1, '{32'h00000000, 1'b1, CMD_NONE, FLAGS_STOP}},
    '{ROW_FRAME, 32'hFFFFFFFF, 1'b1, '{32'hFFFFFFFF, 1'b1, CMD_NONE, FLAGS_STOP}},
    '{ROW_FRAME, 32'h2C674E90, 1'b1, '{32'h2C674E90, 1'b1, CMD_CONF, FLAGS_CONF}}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  cfg_idx_e             cfg_index_i = REG_SYNC_MIN;
  logic [WORD_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [TIME_W-1:0]    low_time_us_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [WORD_W-1:0]    frame_word_o;
  logic                 frame_ok_o;
  logic [2:0]           command_o;
  logic                 pos_drive_on_o;
  logic                 neg_drive_on_o;
  logic                 red_led_on_o;
  logic                 green_led_on_o;
  logic                 red_blink_o;
  logic                 green_blink_o;

  // Decoder state mirrored by the predictor.
  cfg_t        decoder_cfg = RESET_CFG;
  bit          synced = 1'b0;
  logic [6:0]  pulse_count = '0;
  logic [31:0] word_acc = '0;
  flags_t      held_flags = FLAGS_RESET;

  result_t pending_frames[$];
  int      error_count = 0;
  int      frames_seen = 0;
  int      pulses_sent = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_left = 0;
  bit      hold_request = 1'b0;

  pulse_width_rf_frame_decoder_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .low_time_us_i  (low_time_us_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_word_o   (frame_word_o),
    .frame_ok_o     (frame_ok_o),
    .command_o      (command_o),
    .pos_drive_on_o (pos_drive_on_o),
    .neg_drive_on_o (neg_drive_on_o),
    .red_led_on_o   (red_led_on_o),
    .green_led_on_o (green_led_on_o),
    .red_blink_o    (red_blink_o),
    .green_blink_o  (green_blink_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predict the effect of one accepted pulse; a frame word comes out when a frame
  // completes or aborts.
  task automatic decode_pulse(input logic [15:0] width, output bit produced,
                              output result_t frame);
    logic one;
    bit   fail;
    bit   done;
    produced = 1'b0;
    frame = '0;
    fail = 1'b0;
    done = 1'b0;
    if (!synced) begin
      if (width >= decoder_cfg.sync_min) begin
        synced = 1'b1;
        pulse_count = '0;
        word_acc = '0;
      end
    end else begin
      one = width > decoder_cfg.one_thresh;
      fail = (width < decoder_cfg.pulse_min) || (width > decoder_cfg.pulse_max);
      if (!fail) begin
        if (!pulse_count[0]) begin
          word_acc = {word_acc[30:0], one};
        end else if (one == word_acc[0]) begin
          fail = 1'b1;
        end
      end
      if (!fail) begin
        pulse_count = pulse_count + 7'd1;
        done = pulse_count >= PULSES_PER_FRAME;
      end
      if (fail || done) begin
        frame.ok = !fail;
        frame.cmd = CMD_NONE;
        // The first matching code wins when several codes are equal.
        if (done) begin
          if (word_acc == decoder_cfg.code_conf) begin
            frame.cmd = CMD_CONF;
            held_flags = FLAGS_CONF;
          end else if (word_acc == decoder_cfg.code_eco) begin
            frame.cmd = CMD_ECO;
            held_flags = FLAGS_ECO;
          end else if (word_acc == decoder_cfg.code_frost) begin
            frame.cmd = CMD_FROST;
            held_flags = FLAGS_FROST;
          end else if (word_acc == decoder_cfg.code_stop) begin
            frame.cmd = CMD_STOP;
            held_flags = FLAGS_STOP;
          end
        end
        frame.word = word_acc;
        frame.flags = held_flags;
        produced = 1'b1;
        // A sync-length pulse that ends a frame opens the next one at once.
        synced = width >= decoder_cfg.sync_min;
        pulse_count = '0;
        word_acc = '0;
      end
    end
  endtask

  // Pick a legal width for the given bit under the current thresholds, or any
  // width when the thresholds leave no room for that bit.
  function automatic logic [15:0] pick_width(input logic one);
    int lo;
    int hi;
    if (one) begin
      lo = int'(decoder_cfg.one_thresh) + 1;
      if (lo < int'(decoder_cfg.pulse_min)) lo = int'(decoder_cfg.pulse_min);
      hi = int'(decoder_cfg.pulse_max);
    end else begin
      lo = int'(decoder_cfg.pulse_min);
      hi = int'(decoder_cfg.one_thresh);
      if (hi > int'(decoder_cfg.pulse_max)) hi = int'(decoder_cfg.pulse_max);
    end
    if (lo <= hi) return 16'($urandom_range(hi, lo));
    return 16'($urandom_range(16'hFFFF, 0));
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.sync_min = 16'($urandom_range(5000, 1800));
    c.pulse_min = 16'($urandom_range(400, 0));
    c.pulse_max = 16'($urandom_range(2400, 900));
    c.one_thresh = 16'($urandom_range(900, 400));
    c.code_conf = $urandom;
    c.code_eco = $urandom;
    c.code_frost = $urandom;
    c.code_stop = $urandom;
    return c;
  endfunction

  // Offer one pulse word, idling first at random, and predict it once accepted.
  task automatic send_pulse(input logic [15:0] width, input bit typed,
                            input result_t typed_frame);
    bit      produced;
    result_t predicted;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    low_time_us_i <= width;
    do @(posedge clk_i); while (in_stall_o);
    pulses_sent++;
    decode_pulse(width, produced, predicted);
    if (typed) begin
      pending_frames.push_back(typed_frame);
    end else if (produced) begin
      pending_frames.push_back(predicted);
    end
  endtask

  // Send a sync pulse and a whole frame for the given word; the pulse at
  // err_pos, if any, is replaced by err_width.
  task automatic send_frame(input logic [31:0] word, input int err_pos,
                            input logic [15:0] err_width, input bit typed,
                            input result_t typed_frame);
    logic        bit_v;
    logic [15:0] width;
    send_pulse(16'($urandom_range(16'hFFFF, decoder_cfg.sync_min)), 1'b0, NO_FRAME);
    for (int i = 0; i < PULSES_PER_FRAME; i++) begin
      bit_v = word[31 - i / 2] ^ i[0];
      width = (i == err_pos) ? err_width : pick_width(bit_v);
      send_pulse(width, typed && (i == PULSES_PER_FRAME - 1), typed_frame);
    end
  endtask

  // Write all registers in index order; the block must be idle.
  task automatic load_config(input cfg_t c);
    cfg_idx_e idx;
    idx = REG_SYNC_MIN;
    repeat (8) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      case (idx)
        REG_SYNC_MIN:   cfg_data_i <= {16'($urandom), c.sync_min};
        REG_PULSE_MIN:  cfg_data_i <= {16'($urandom), c.pulse_min};
        REG_PULSE_MAX:  cfg_data_i <= {16'($urandom), c.pulse_max};
        REG_ONE_THRESH: cfg_data_i <= {16'($urandom), c.one_thresh};
        REG_CODE_CONF:  cfg_data_i <= c.code_conf;
        REG_CODE_ECO:   cfg_data_i <= c.code_eco;
        REG_CODE_FROST: cfg_data_i <= c.code_frost;
        default:        cfg_data_i <= c.code_stop;
      endcase
      do @(posedge clk_i); while (!cfg_ready_o);
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
    decoder_cfg = c;
  endtask

  // Drop valid, wait for every expected frame word, then cover the pipeline.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic compare_frame(input result_t want);
    report_field("frame_word", want.word, frame_word_o);
    report_field("frame_ok", want.ok, frame_ok_o);
    report_field("command", want.cmd, command_o);
    report_field("pos_drive_on", want.flags.pos_drive, pos_drive_on_o);
    report_field("neg_drive_on", want.flags.neg_drive, neg_drive_on_o);
    report_field("red_led_on", want.flags.red_led, red_led_on_o);
    report_field("green_led_on", want.flags.green_led, green_led_on_o);
    report_field("red_blink", want.flags.red_blink, red_blink_o);
    report_field("green_blink", want.flags.green_blink, green_blink_o);
  endtask

  // Output side: check each accepted word, then choose the stall for the next
  // cycle, with a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      frames_seen++;
      if (pending_frames.size() == 0) begin
        error_count++;
        $display("%0t: frame word expected none actual %0h", $time, frame_word_o);
      end else begin
        compare_frame(pending_frames.pop_front());
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // Watchdog: end the run when no word moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases under several settings.
  initial begin : stimulus
    cfg_t        c;
    int          first;
    int          pick;
    logic [31:0] word;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 34;
    recv_idle_pct = 47;

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_PULSE) begin
        send_pulse(DIRECTED_ROWS[i].value[15:0], DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].frame);
      end else begin
        send_frame(DIRECTED_ROWS[i].value, NO_ERROR, 16'h0, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].frame);
      end
    end
    settle();

    for (int s = 0; s < SETTINGS_COUNT; s++) begin
      case (s / 2)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (s)
        0: c = RESET_CFG;
        1, 5: c = random_config();
        2: c = '0;
        3: c = '1;
        default: begin
          // Data pulses may reach sync length, and all codes are equal.
          c = random_config();
          c.sync_min = 16'd1000;
          c.pulse_min = 16'd100;
          c.pulse_max = 16'hFFFF;
          c.one_thresh = 16'd600;
          c.code_eco = c.code_conf;
          c.code_frost = c.code_conf;
          c.code_stop = c.code_conf;
        end
      endcase
      load_config(c);

      // Hold the output off while aborting pulses keep coming, so the block
      // fills up and stalls its input.
      if (s == SETTINGS_COUNT - 1) begin
        hold_request = 1'b1;
        repeat (60) send_pulse(16'hFFFF - 16'($urandom_range(999, 0)), 1'b0, NO_FRAME);
      end

      first = pulses_sent;
      while ((pulses_sent - first) < RANDOM_PER_SETTING ||
             (s == SETTINGS_COUNT - 1 && frames_seen < 60)) begin
        pick = $urandom_range(99, 0);
        if (pick < 55) begin
          case ($urandom_range(5, 0))
            0: word = decoder_cfg.code_conf;
            1: word = decoder_cfg.code_eco;
            2: word = decoder_cfg.code_frost;
            3: word = decoder_cfg.code_stop;
            4: word = $urandom;
            default: word = decoder_cfg.code_conf ^ (32'h1 << $urandom_range(31, 0));
          endcase
          if ($urandom_range(1, 0)) begin
            send_frame(word, NO_ERROR, 16'h0, 1'b0, NO_FRAME);
          end else begin
            send_frame(word, $urandom_range(62, 0), 16'($urandom), 1'b0, NO_FRAME);
          end
        end else if (pick < 80) begin
          // A sync pulse followed by a few pulses that are often malformed.
          send_pulse(16'($urandom_range(16'hFFFF, decoder_cfg.sync_min)), 1'b0, NO_FRAME);
          repeat ($urandom_range(4, 1)) begin
            if ($urandom_range(1, 0)) begin
              send_pulse(pick_width($urandom_range(1, 0)), 1'b0, NO_FRAME);
            end else begin
              send_pulse(16'($urandom), 1'b0, NO_FRAME);
            end
          end
        end else begin
          send_pulse(16'($urandom), 1'b0, NO_FRAME);
        end
      end
      settle();
    end

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/pwrfd_pkg.sv
src/pwrfd_cfg_regs.sv
src/pwrfd_decode.sv
src/pwrfd_out_reg.sv
src/pulse_width_rf_frame_decoder_core.sv
sim/pulse_width_rf_frame_decoder_core_tb.sv
